// ===== rtl/lte_pkg.sv =====
// Shared types and constants for the line text buffer editor.
// Depends on nothing; every other file imports it.
package lte_pkg;

  localparam int LINES    = 128;
  localparam int LINE_LEN = 256;
  localparam int ROW_W    = $clog2(LINES);
  localparam int COL_W    = $clog2(LINE_LEN);
  localparam int CNT_W    = ROW_W + 1;
  localparam int ADDR_W   = ROW_W + COL_W;

  // Longest line, in characters.
  localparam logic [COL_W-1:0] LEN_MAX = COL_W'(LINE_LEN - 1);

  localparam logic [7:0] KEY_BS       = 8'd8;
  localparam logic [7:0] KEY_LF       = 8'd10;
  localparam logic [7:0] KEY_CR       = 8'd13;
  localparam logic [7:0] KEY_QUIT     = 8'd17;
  localparam logic [7:0] KEY_SAVE     = 8'd19;
  localparam logic [7:0] KEY_PRINT_LO = 8'd32;
  localparam logic [7:0] KEY_PRINT_HI = 8'd126;
  localparam logic [7:0] KEY_DEL      = 8'd127;
  localparam logic [7:0] KEY_UP       = 8'h80;
  localparam logic [7:0] KEY_DOWN     = 8'h81;
  localparam logic [7:0] KEY_LEFT     = 8'h82;
  localparam logic [7:0] KEY_RIGHT    = 8'h83;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_UNKNOWN = 3'd1,
    ST_QUIT    = 3'd2,
    ST_SAVE    = 3'd3,
    ST_READ    = 3'd4
  } status_t;

  // One line table entry: physical slot of the line in the text memory and its length.
  typedef struct packed {
    logic [ROW_W-1:0] slot;
    logic [COL_W-1:0] len;
  } lt_entry_t;

  typedef enum logic [1:0] {
    OP_INS,
    OP_DEL,
    OP_JOIN,
    OP_ENTER
  } op_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_LOOK,
    S_LOOK_W,
    S_RTXT,
    S_MOV_RD,
    S_MOV_W,
    S_JOIN_RD,
    S_JOIN_W,
    S_ENT_RD,
    S_ENT_W,
    S_T_RD,
    S_T_WR,
    S_L_RD,
    S_L_WR,
    S_INS_FIN,
    S_DEL_FIN,
    S_JOIN_LEN,
    S_JOIN_TAIL,
    S_ENT_NEW,
    S_ENT_CUR,
    S_DONE
  } state_t;

endpackage

// ===== rtl/lte_if.sv =====
// Handshake channels of the line text buffer editor: key/read commands and results.
// Depends on lte_pkg for the field widths.
interface lte_cmd_if import lte_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             func;
  logic [7:0]       key_code;
  logic [ROW_W-1:0] read_row;
  logic [COL_W-1:0] read_col;

  modport source (output valid, func, key_code, read_row, read_col, input ready);
  modport sink   (input valid, func, key_code, read_row, read_col, output ready);
endinterface

interface lte_res_if import lte_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [2:0]       status;
  logic [COL_W-1:0] cursor_col;
  logic [ROW_W-1:0] cursor_row;
  logic [CNT_W-1:0] lines_used;
  logic             dirty;
  logic [7:0]       read_char;
  logic [COL_W-1:0] read_len;

  modport source (output valid, status, cursor_col, cursor_row, lines_used, dirty,
                  read_char, read_len, input ready);
  modport sink   (input valid, status, cursor_col, cursor_row, lines_used, dirty,
                  read_char, read_len, output ready);
endinterface

// ===== rtl/line_text_buffer_editor_unit.sv =====
// Top level of the line text buffer editor: text memory, line table and sequencer.
// Depends on lte_pkg and the channel interfaces in lte_if.sv.
//
//  Channel | Direction | Transaction
//  cmd     | in        | one key code or one read request (func, key_code, read_row, read_col)
//  res     | out       | one result per command (status, cursor, line count, dirty, read data)
//
// Commands are handled one at a time. Insert and delete shift the tail of the line one
// character at a time. Enter and a line join copy characters one at a time and then move
// line table entries one at a time. Each memory has a single read port and a single write
// port. Reset is synchronous; there is no clearing pass. A stalled result holds the
// sequencer in its final state until it is taken.
module line_text_buffer_editor_unit import lte_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  lte_cmd_if.sink   cmd,
  lte_res_if.source res
);

  // The text memory holds one row of LINE_LEN characters per physical slot. The lines below the
  // cursor are never copied: the line table maps each logical line to a slot, and enter and join
  // rotate table entries instead. The table always holds a permutation of the slots.
  logic [7:0]       text_mem [LINES*LINE_LEN];
  logic [ADDR_W-1:0] t_raddr, t_waddr;
  logic [7:0]       t_rdata, t_wdata;
  logic             t_we;

  always_ff @(posedge clk) begin
    if (t_we) begin
      text_mem[t_waddr] <= t_wdata;
    end
    t_rdata <= text_mem[t_raddr];
  end

  // Line table. An entry that was never written reads as its own slot with length zero,
  // which gives the empty buffer after reset.
  lt_entry_t        lt_mem [LINES];
  logic [LINES-1:0] lt_vld;
  logic [ROW_W-1:0] lt_raddr, lt_waddr, lt_rix;
  lt_entry_t        lt_raw, lt_wdata, lt_eff;
  logic             lt_we, lt_rvld;

  always_ff @(posedge clk) begin
    if (lt_we) begin
      lt_mem[lt_waddr] <= lt_wdata;
    end
    lt_raw  <= lt_mem[lt_raddr];
    lt_rvld <= lt_vld[lt_raddr];
    lt_rix  <= lt_raddr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lt_vld <= '0;
    end else if (lt_we) begin
      lt_vld[lt_waddr] <= 1'b1;
    end
  end

  assign lt_eff = lt_rvld ? lt_raw : '{slot: lt_rix, len: '0};

  // Sequencer registers.
  state_t            state, state_next;
  op_t               op, op_next;
  logic              f_func, f_func_next;
  logic [7:0]        f_key, f_key_next;
  logic [ROW_W-1:0]  f_rr, f_rr_next;
  logic [COL_W-1:0]  f_rc, f_rc_next;
  logic [ROW_W-1:0]  cur_slot, cur_slot_next, aux_slot, aux_slot_next;
  logic [COL_W-1:0]  cur_len, cur_len_next, aux_len, aux_len_next;
  logic [COL_W:0]    col_c, col_c_next;
  logic [ADDR_W-1:0] cp_src, cp_src_next, cp_dst, cp_dst_next;
  logic [COL_W-1:0]  cp_cnt, cp_cnt_next;
  logic              cp_down, cp_down_next;
  logic [ROW_W-1:0]  lc_src, lc_src_next, lc_dst, lc_dst_next, lc_cnt, lc_cnt_next;
  logic              lc_down, lc_down_next;
  logic [ROW_W-1:0]  row_pos, row_pos_next;
  logic [COL_W-1:0]  col_pos, col_pos_next;
  logic [CNT_W-1:0]  used, used_next;
  logic              dirty, dirty_next;
  status_t           stat, stat_next;
  logic [7:0]        rd_char, rd_char_next;
  logic [COL_W-1:0]  rd_len, rd_len_next;
  logic              ovalid, ovalid_next, oload;

  // Result register.
  logic [2:0]        o_status;
  logic [COL_W-1:0]  o_col, o_len;
  logic [ROW_W-1:0]  o_row;
  logic [CNT_W-1:0]  o_used;
  logic              o_dirty;
  logic [7:0]        o_char;

  logic              is_enter, is_del, is_print, is_move;
  logic [COL_W-1:0]  clamp_col;
  logic [COL_W:0]    join_sum;
  logic [ROW_W-1:0]  used_m1;

  assign is_enter = (f_key == KEY_LF) || (f_key == KEY_CR);
  assign is_del   = (f_key == KEY_BS) || (f_key == KEY_DEL);
  assign is_print = (f_key >= KEY_PRINT_LO) && (f_key <= KEY_PRINT_HI);
  assign is_move  = (f_key >= KEY_UP) && (f_key <= KEY_RIGHT);
  assign clamp_col = (col_pos > lt_eff.len) ? lt_eff.len : col_pos;
  assign join_sum  = {1'b0, lt_eff.len} + {1'b0, cur_len};
  assign used_m1   = ROW_W'(used - CNT_W'(1));

  assign cmd.ready = (state == S_IDLE);

  always_comb begin
    state_next    = state;
    op_next       = op;
    f_func_next   = f_func;
    f_key_next    = f_key;
    f_rr_next     = f_rr;
    f_rc_next     = f_rc;
    cur_slot_next = cur_slot;
    cur_len_next  = cur_len;
    aux_slot_next = aux_slot;
    aux_len_next  = aux_len;
    col_c_next    = col_c;
    cp_src_next   = cp_src;
    cp_dst_next   = cp_dst;
    cp_cnt_next   = cp_cnt;
    cp_down_next  = cp_down;
    lc_src_next   = lc_src;
    lc_dst_next   = lc_dst;
    lc_cnt_next   = lc_cnt;
    lc_down_next  = lc_down;
    row_pos_next  = row_pos;
    col_pos_next  = col_pos;
    used_next     = used;
    dirty_next    = dirty;
    stat_next     = stat;
    rd_char_next  = rd_char;
    rd_len_next   = rd_len;
    t_raddr  = cp_src;
    t_we     = 1'b0;
    t_waddr  = cp_dst;
    t_wdata  = t_rdata;
    lt_raddr = row_pos;
    lt_we    = 1'b0;
    lt_waddr = lc_dst;
    lt_wdata = lt_eff;
    oload    = 1'b0;

    case (state)
      S_IDLE: begin
        if (cmd.valid) begin
          f_func_next  = cmd.func;
          f_key_next   = cmd.key_code;
          f_rr_next    = cmd.read_row;
          f_rc_next    = cmd.read_col;
          rd_char_next = '0;
          rd_len_next  = '0;
          stat_next    = ST_OK;
          state_next   = S_LOOK;
        end
      end

      // Fetch the table entry of the read row or of the cursor line.
      S_LOOK: begin
        lt_raddr   = f_func ? f_rr : row_pos;
        state_next = S_LOOK_W;
      end

      S_LOOK_W: begin
        cur_slot_next = lt_eff.slot;
        cur_len_next  = lt_eff.len;
        state_next    = S_DONE;
        if (f_func) begin
          stat_next = ST_READ;
          if ({1'b0, f_rr} < used) begin
            rd_len_next = lt_eff.len;
            if (f_rc < lt_eff.len) begin
              t_raddr    = {lt_eff.slot, f_rc};
              state_next = S_RTXT;
            end
          end
        end else if (f_key == KEY_QUIT) begin
          stat_next = ST_QUIT;
        end else if (f_key == KEY_SAVE) begin
          stat_next  = ST_SAVE;
          dirty_next = 1'b0;
        end else if (is_enter) begin
          if (used != CNT_W'(LINES) && col_pos <= lt_eff.len) begin
            state_next = S_ENT_RD;
          end
        end else if (is_del) begin
          dirty_next = 1'b1;
          if (col_pos != '0 && lt_eff.len != '0) begin
            // Shift the tail of the line one place left.
            col_c_next   = {1'b0, clamp_col};
            cp_src_next  = {lt_eff.slot, clamp_col};
            cp_dst_next  = {lt_eff.slot, clamp_col - COL_W'(1)};
            cp_cnt_next  = lt_eff.len - clamp_col;
            cp_down_next = 1'b0;
            op_next      = OP_DEL;
            state_next   = S_T_RD;
          end else if (col_pos == '0 && row_pos != '0) begin
            state_next = S_JOIN_RD;
          end
        end else if (is_print) begin
          if (col_pos != LEN_MAX && lt_eff.len != LEN_MAX) begin
            // Shift the tail one place right, starting from its last character.
            col_c_next   = {1'b0, clamp_col};
            cp_src_next  = {lt_eff.slot, lt_eff.len - COL_W'(1)};
            cp_dst_next  = {lt_eff.slot, lt_eff.len};
            cp_cnt_next  = lt_eff.len - clamp_col;
            cp_down_next = 1'b1;
            op_next      = OP_INS;
            state_next   = S_T_RD;
          end
        end else if (is_move) begin
          col_c_next = {1'b0, col_pos};
          case (f_key)
            KEY_UP: begin
              if (row_pos != '0) begin
                row_pos_next = row_pos - ROW_W'(1);
              end
            end
            KEY_DOWN: begin
              if ({1'b0, row_pos} + CNT_W'(1) < used) begin
                row_pos_next = row_pos + ROW_W'(1);
              end
            end
            KEY_LEFT: begin
              if (col_pos != '0) begin
                col_c_next = {1'b0, col_pos - COL_W'(1)};
              end
            end
            default: begin
              col_c_next = {1'b0, col_pos} + (COL_W+1)'(1);
            end
          endcase
          state_next = S_MOV_RD;
        end else begin
          stat_next = ST_UNKNOWN;
        end
      end

      S_RTXT: begin
        rd_char_next = t_rdata;
        state_next   = S_DONE;
      end

      // Clamp the column to the length of the line the cursor ends on.
      S_MOV_RD: begin
        lt_raddr   = row_pos;
        state_next = S_MOV_W;
      end

      S_MOV_W: begin
        col_pos_next = (col_c > {1'b0, lt_eff.len}) ? lt_eff.len : col_c[COL_W-1:0];
        state_next   = S_DONE;
      end

      S_JOIN_RD: begin
        lt_raddr   = row_pos - ROW_W'(1);
        state_next = S_JOIN_W;
      end

      // Join only when the combined line stays short of the longest line.
      S_JOIN_W: begin
        state_next = S_DONE;
        if (join_sum < {1'b0, LEN_MAX}) begin
          aux_slot_next = lt_eff.slot;
          aux_len_next  = lt_eff.len;
          cp_src_next   = {cur_slot, COL_W'(0)};
          cp_dst_next   = {lt_eff.slot, lt_eff.len};
          cp_cnt_next   = cur_len;
          cp_down_next  = 1'b0;
          op_next       = OP_JOIN;
          state_next    = S_T_RD;
        end
      end

      // The first unused table entry lends its slot to the new line.
      S_ENT_RD: begin
        lt_raddr   = used[ROW_W-1:0];
        state_next = S_ENT_W;
      end

      S_ENT_W: begin
        aux_slot_next = lt_eff.slot;
        cp_src_next   = {cur_slot, col_pos};
        cp_dst_next   = {lt_eff.slot, COL_W'(0)};
        cp_cnt_next   = cur_len - col_pos;
        cp_down_next  = 1'b0;
        op_next       = OP_ENTER;
        state_next    = S_T_RD;
      end

      // Character copy loop: read one character, write it next cycle.
      S_T_RD: begin
        if (cp_cnt == '0) begin
          case (op)
            OP_INS:  state_next = S_INS_FIN;
            OP_DEL:  state_next = S_DEL_FIN;
            OP_JOIN: state_next = S_JOIN_LEN;
            default: begin
              lc_src_next  = used_m1;
              lc_dst_next  = used[ROW_W-1:0];
              lc_cnt_next  = ROW_W'(used - {1'b0, row_pos} - CNT_W'(1));
              lc_down_next = 1'b1;
              state_next   = S_L_RD;
            end
          endcase
        end else begin
          t_raddr    = cp_src;
          state_next = S_T_WR;
        end
      end

      S_T_WR: begin
        t_we        = 1'b1;
        t_waddr     = cp_dst;
        t_wdata     = t_rdata;
        cp_src_next = cp_down ? cp_src - ADDR_W'(1) : cp_src + ADDR_W'(1);
        cp_dst_next = cp_down ? cp_dst - ADDR_W'(1) : cp_dst + ADDR_W'(1);
        cp_cnt_next = cp_cnt - COL_W'(1);
        state_next  = S_T_RD;
      end

      // Line table rotation loop, same read-then-write pattern.
      S_L_RD: begin
        if (lc_cnt == '0) begin
          state_next = (op == OP_JOIN) ? S_JOIN_TAIL : S_ENT_NEW;
        end else begin
          lt_raddr   = lc_src;
          state_next = S_L_WR;
        end
      end

      S_L_WR: begin
        lt_we       = 1'b1;
        lt_waddr    = lc_dst;
        lt_wdata    = lt_eff;
        lc_src_next = lc_down ? lc_src - ROW_W'(1) : lc_src + ROW_W'(1);
        lc_dst_next = lc_down ? lc_dst - ROW_W'(1) : lc_dst + ROW_W'(1);
        lc_cnt_next = lc_cnt - ROW_W'(1);
        state_next  = S_L_RD;
      end

      S_INS_FIN: begin
        t_we         = 1'b1;
        t_waddr      = {cur_slot, col_c[COL_W-1:0]};
        t_wdata      = f_key;
        lt_we        = 1'b1;
        lt_waddr     = row_pos;
        lt_wdata     = '{slot: cur_slot, len: cur_len + COL_W'(1)};
        col_pos_next = col_c[COL_W-1:0] + COL_W'(1);
        dirty_next   = 1'b1;
        state_next   = S_DONE;
      end

      S_DEL_FIN: begin
        lt_we        = 1'b1;
        lt_waddr     = row_pos;
        lt_wdata     = '{slot: cur_slot, len: cur_len - COL_W'(1)};
        col_pos_next = col_c[COL_W-1:0] - COL_W'(1);
        state_next   = S_DONE;
      end

      // Lengthen the line above, then close the gap left by the joined line.
      S_JOIN_LEN: begin
        lt_we        = 1'b1;
        lt_waddr     = row_pos - ROW_W'(1);
        lt_wdata     = '{slot: aux_slot, len: aux_len + cur_len};
        lc_src_next  = row_pos + ROW_W'(1);
        lc_dst_next  = row_pos;
        lc_cnt_next  = ROW_W'(used - {1'b0, row_pos} - CNT_W'(1));
        lc_down_next = 1'b0;
        state_next   = S_L_RD;
      end

      // The freed slot goes to the entry just past the shortened text.
      S_JOIN_TAIL: begin
        lt_we        = 1'b1;
        lt_waddr     = used_m1;
        lt_wdata     = '{slot: cur_slot, len: COL_W'(0)};
        used_next    = used - CNT_W'(1);
        row_pos_next = row_pos - ROW_W'(1);
        col_pos_next = aux_len;
        state_next   = S_DONE;
      end

      S_ENT_NEW: begin
        lt_we      = 1'b1;
        lt_waddr   = row_pos + ROW_W'(1);
        lt_wdata   = '{slot: aux_slot, len: cur_len - col_pos};
        state_next = S_ENT_CUR;
      end

      S_ENT_CUR: begin
        lt_we        = 1'b1;
        lt_waddr     = row_pos;
        lt_wdata     = '{slot: cur_slot, len: col_pos};
        used_next    = used + CNT_W'(1);
        row_pos_next = row_pos + ROW_W'(1);
        col_pos_next = '0;
        dirty_next   = 1'b1;
        state_next   = S_DONE;
      end

      S_DONE: begin
        if (!ovalid || res.ready) begin
          oload      = 1'b1;
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase

    ovalid_next = oload ? 1'b1 : (ovalid && !res.ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      ovalid  <= 1'b0;
      row_pos <= '0;
      col_pos <= '0;
      used    <= CNT_W'(1);
      dirty   <= 1'b0;
    end else begin
      state   <= state_next;
      ovalid  <= ovalid_next;
      row_pos <= row_pos_next;
      col_pos <= col_pos_next;
      used    <= used_next;
      dirty   <= dirty_next;
    end
  end

  always_ff @(posedge clk) begin
    op       <= op_next;
    f_func   <= f_func_next;
    f_key    <= f_key_next;
    f_rr     <= f_rr_next;
    f_rc     <= f_rc_next;
    cur_slot <= cur_slot_next;
    cur_len  <= cur_len_next;
    aux_slot <= aux_slot_next;
    aux_len  <= aux_len_next;
    col_c    <= col_c_next;
    cp_src   <= cp_src_next;
    cp_dst   <= cp_dst_next;
    cp_cnt   <= cp_cnt_next;
    cp_down  <= cp_down_next;
    lc_src   <= lc_src_next;
    lc_dst   <= lc_dst_next;
    lc_cnt   <= lc_cnt_next;
    lc_down  <= lc_down_next;
    stat     <= stat_next;
    rd_char  <= rd_char_next;
    rd_len   <= rd_len_next;
    if (oload) begin
      o_status <= stat;
      o_col    <= col_pos;
      o_row    <= row_pos;
      o_used   <= used;
      o_dirty  <= dirty;
      o_char   <= rd_char;
      o_len    <= rd_len;
    end
  end

  assign res.valid      = ovalid;
  assign res.status     = o_status;
  assign res.cursor_col = o_col;
  assign res.cursor_row = o_row;
  assign res.lines_used = o_used;
  assign res.dirty      = o_dirty;
  assign res.read_char  = o_char;
  assign res.read_len   = o_len;

endmodule
